FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/htfd_pkg.sv
package htfd_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Byte positions within a six-byte reply
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [13:0] HUM_SPAN    = 14'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;
    localparam logic [16:0] RAW_FULL    = 17'd65535;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_hum;
        logic        temp_ok;
        logic        hum_ok;
    } frame_t;

    // Field order matches the result tdata, lowest field last
    typedef struct packed {
        logic               updated;
        logic               hum_ok;
        logic               temp_ok;
        logic        [13:0] humidity;
        logic signed [14:0] temperature;
    } result_t;

    // CRC-8, MSB first, no reflection, no final XOR
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/htfd_front.sv
module htfd_front
    import htfd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic [7:0] data_byte,
    input  logic       frame_start,
    output logic       push,
    output frame_t     push_frame
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  hi_reg, hi_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        tok_reg, tok_next;

    logic [2:0]  pos;
    logic [7:0]  crc_seed;
    logic [7:0]  crc_new;

    always_comb begin
        pos = frame_start ? POS_T_MSB : pos_reg;
        if (pos > POS_H_CRC) begin
            pos = POS_T_MSB;
        end
        crc_seed = (pos == POS_T_MSB || pos == POS_H_MSB) ? CRC_INIT : crc_reg;
        crc_new  = crc8_byte(crc_seed, data_byte);
    end

    always_comb begin
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        hi_next    = hi_reg;
        raw_t_next = raw_t_reg;
        raw_h_next = raw_h_reg;
        tok_next   = tok_reg;
        if (in_fire) begin
            pos_next = (pos == POS_H_CRC) ? POS_T_MSB : pos + 3'd1;
            case (pos)
                POS_T_MSB, POS_H_MSB: begin
                    crc_next = crc_new;
                    hi_next  = data_byte;
                end
                POS_T_LSB: begin
                    crc_next   = crc_new;
                    raw_t_next = {hi_reg, data_byte};
                end
                POS_H_LSB: begin
                    crc_next   = crc_new;
                    raw_h_next = {hi_reg, data_byte};
                end
                POS_T_CRC: begin
                    tok_next = (crc_reg == data_byte);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_T_MSB;
            crc_reg   <= CRC_INIT;
            hi_reg    <= '0;
            raw_t_reg <= '0;
            raw_h_reg <= '0;
            tok_reg   <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            hi_reg    <= hi_next;
            raw_t_reg <= raw_t_next;
            raw_h_reg <= raw_h_next;
            tok_reg   <= tok_next;
        end
    end

    // Hand the finished frame over on its humidity CRC byte
    assign push                = in_fire && (pos == POS_H_CRC);
    assign push_frame.raw_temp = raw_t_reg;
    assign push_frame.raw_hum  = raw_h_reg;
    assign push_frame.temp_ok  = tok_reg;
    assign push_frame.hum_ok   = (crc_reg == data_byte);

endmodule

FILE: rtl/core/htfd_queue.sv
module htfd_queue
    import htfd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   pop_valid,
    output frame_t pop_frame
);

    frame_t     entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_frame = entry_reg[rd_ptr_reg];

endmodule

FILE: rtl/core/htfd_back.sv
module htfd_back
    import htfd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    frame_valid,
    input  frame_t  frame,
    output logic    frame_pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    // Product stage
    logic        s1_valid_reg, s1_valid_next;
    logic [30:0] prod_t_reg;
    logic [29:0] prod_h_reg;
    logic        s1_tok_reg;
    logic        s1_hok_reg;

    // Result stage and held values
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    logic signed [14:0] last_t_reg;
    logic        [13:0] last_h_reg;

    logic        out_free;
    logic        s1_free;
    logic        s1_move;
    logic [16:0] sum_t;
    logic [16:0] sum_h;
    logic [14:0] quot_t;
    logic [13:0] quot_h;
    logic signed [14:0] new_t;
    logic        upd;

    assign out_free  = !out_valid_reg || res_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || out_free;
    assign frame_pop = frame_valid && s1_free;

    // x / 65535 with x = q * 65536 + r is q plus one when q + r reaches 65535
    always_comb begin
        sum_t  = {2'b00, prod_t_reg[30:16]} + {1'b0, prod_t_reg[15:0]};
        sum_h  = {3'b000, prod_h_reg[29:16]} + {1'b0, prod_h_reg[15:0]};
        quot_t = prod_t_reg[30:16] + {14'd0, (sum_t >= RAW_FULL)};
        quot_h = prod_h_reg[29:16] + {13'd0, (sum_h >= RAW_FULL)};
        new_t  = signed'(quot_t - TEMP_OFFSET);
        upd    = s1_tok_reg && s1_hok_reg;
    end

    always_comb begin
        s1_valid_next  = frame_pop ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_move ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_t_reg    <= '0;
            last_h_reg    <= '0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_move && upd) begin
                last_t_reg <= new_t;
                last_h_reg <= quot_h;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_pop) begin
            prod_t_reg <= 31'(frame.raw_temp) * 31'(TEMP_SPAN);
            prod_h_reg <= 30'(frame.raw_hum) * 30'(HUM_SPAN);
            s1_tok_reg <= frame.temp_ok;
            s1_hok_reg <= frame.hum_ok;
        end
        if (s1_move) begin
            out_reg.updated     <= upd;
            out_reg.hum_ok      <= s1_hok_reg;
            out_reg.temp_ok     <= s1_tok_reg;
            out_reg.humidity    <= upd ? quot_h : last_h_reg;
            out_reg.temperature <= upd ? new_t : last_t_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: rtl/core/humidity_temp_frame_decoder.sv
// Sensor reply decoder: takes the six reply bytes (temperature MSB, LSB, CRC, humidity MSB,
// LSB, CRC) one per request on the s_ side, checks each word with CRC-8 (poly 0x31, init
// 0xFF), and after the sixth byte sends one result on the m_ side carrying both CRC flags
// and the last good temperature (centidegrees) and humidity (centipercent). s_tuser high
// restarts the byte position. One byte is taken every cycle unless the input stalls; the
// result of a frame passes through the frame queue, the product register and the output
// register. The input stalls only while the two-entry frame queue is full, which takes
// the output held back for about three frames of back-to-back bytes with a result
// already waiting.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    // [14:0] temperature_centi, [28:15] humidity_centi, [29] temp_crc_ok,
    // [30] hum_crc_ok, [31] updated
    output logic [31:0] m_tdata
);

    logic    in_fire;
    logic    push;
    frame_t  push_frame;
    logic    full;
    logic    pop;
    logic    pop_valid;
    frame_t  pop_frame;
    result_t res;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    htfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .push_frame  (push_frame)
    );

    htfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .full       (full),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_frame  (pop_frame)
    );

    htfd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (pop_valid),
        .frame       (pop_frame),
        .frame_pop   (pop),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = res;

endmodule

FILE: rtl/core/htfd_checker.sv
`include "assert_macros.svh"

module htfd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `ASSERT_CLK(a_upd_needs_both, aclk, aresetn, m_tvalid && m_tdata[31] |-> m_tdata[29] && m_tdata[30], "update without both CRCs")
    `ASSERT_CLK(a_hum_range, aclk, aresetn, m_tvalid |-> m_tdata[28:15] <= 14'd10000, "humidity out of range")

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (.*);

FILE: tb/tb_humidity_temp_frame_decoder.sv
module tb_humidity_temp_frame_decoder
    import htfd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AT      = 500;
    localparam int CALM_FROM    = 1100;
    localparam int CALM_TO      = 1400;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         typed;
        result_t    reading;
    } stim_row_t;

    typedef struct {
        bit      typed;
        result_t reading;
    } reading_tag_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // decoder state as the testbench sees it
    logic [2:0]         frame_pos;
    logic [7:0]         crc_acc;
    logic [7:0]         msb_hold;
    logic [15:0]        raw_t_hold;
    logic [15:0]        raw_h_hold;
    logic               t_ok_hold;
    logic signed [14:0] good_temp;
    logic [13:0]        good_hum;

    result_t      pending_readings[$];
    reading_tag_t tag_q[$];
    stim_row_t    dir_rows[$];

    int fail_count = 0;
    int sent_count = 0;
    int cycle_count = 0;
    int gen_pos = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    humidity_temp_frame_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] r;
        r = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the frame decode by one byte; returns 1 when a reading is due
    function automatic bit decode_reply_byte(input logic [7:0] b, input logic st,
                                             output result_t r);
        logic [2:0] pos;
        bit         h_ok;
        longint     t_scaled;
        longint     h_scaled;
        r = '0;
        pos = st ? POS_T_MSB : frame_pos;
        if (pos > POS_H_CRC) begin
            pos = POS_T_MSB;
        end
        case (pos)
            POS_T_MSB, POS_H_MSB: begin
                crc_acc  = crc_step(CRC_INIT, b);
                msb_hold = b;
            end
            POS_T_LSB: begin
                crc_acc    = crc_step(crc_acc, b);
                raw_t_hold = {msb_hold, b};
            end
            POS_H_LSB: begin
                crc_acc    = crc_step(crc_acc, b);
                raw_h_hold = {msb_hold, b};
            end
            POS_T_CRC: begin
                t_ok_hold = (crc_acc == b);
            end
            default: ;
        endcase
        if (pos != POS_H_CRC) begin
            frame_pos = pos + 3'd1;
            return 1'b0;
        end
        h_ok = (crc_acc == b);
        if (t_ok_hold && h_ok) begin
            t_scaled = longint'(raw_t_hold) * longint'(TEMP_SPAN) / longint'(RAW_FULL)
                       - longint'(TEMP_OFFSET);
            h_scaled = longint'(raw_h_hold) * longint'(HUM_SPAN) / longint'(RAW_FULL);
            good_temp = t_scaled[14:0];
            good_hum  = h_scaled[13:0];
        end
        frame_pos     = POS_T_MSB;
        r.temperature = good_temp;
        r.humidity    = good_hum;
        r.temp_ok     = t_ok_hold;
        r.hum_ok      = h_ok;
        r.updated     = t_ok_hold & h_ok;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic add_row(input logic [7:0] d, input logic st, input bit typed,
                           input int t, input int h, input bit tok, input bit hok,
                           input bit upd);
        stim_row_t row;
        row.data                = d;
        row.start               = st;
        row.typed               = typed;
        row.reading             = '0;
        row.reading.temperature = t[14:0];
        row.reading.humidity    = h[13:0];
        row.reading.temp_ok     = tok;
        row.reading.hum_ok      = hok;
        row.reading.updated     = upd;
        dir_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic st, input bit typed,
                             input result_t r);
        reading_tag_t tag;
        int           gap;
        tag.typed   = typed;
        tag.reading = r;
        tag_q.push_back(tag);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        gen_pos = st ? 1 : ((gen_pos >= 5) ? 0 : gen_pos + 1);
        if (!calm && $urandom_range(99) < 3) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(19))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send the first len bytes of a reply; corrupt bit 0 spoils the temperature CRC,
    // bit 1 the humidity CRC
    task automatic send_frame(input int len, input logic [1:0] corrupt);
        logic [15:0] rt;
        logic [15:0] rh;
        logic [7:0]  bytes [6];
        logic        st;
        rt = pick_raw();
        rh = pick_raw();
        bytes[0] = rt[15:8];
        bytes[1] = rt[7:0];
        bytes[2] = word_crc(rt) ^ (corrupt[0] ? 8'($urandom_range(1, 255)) : 8'h00);
        bytes[3] = rh[15:8];
        bytes[4] = rh[7:0];
        bytes[5] = word_crc(rh) ^ (corrupt[1] ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < len; i++) begin
            st = (i == 0) && (gen_pos != 0 || $urandom_range(1) == 1);
            send_byte(bytes[i], st, 1'b0, '0);
        end
    endtask

    // request side: run the decoder view on every accepted byte
    always @(posedge aclk) begin : req_monitor
        reading_tag_t tag;
        result_t      pred;
        bit           emit;
        if (aresetn && s_tvalid && s_tready) begin
            tag  = tag_q.pop_front();
            emit = decode_reply_byte(s_tdata, s_tuser, pred);
            if (emit) begin
                pending_readings.push_back(tag.typed ? tag.reading : pred);
            end
        end
    end

    always @(posedge aclk) begin : reading_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_readings.size() == 0) begin
                $display("%0t: reading with none expected, expected none, actual %h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_readings.pop_front();
                check_field("temperature", want.temperature, got.temperature);
                check_field("humidity", want.humidity, got.humidity);
                check_field("temp_crc_ok", want.temp_ok, got.temp_ok);
                check_field("hum_crc_ok", want.hum_ok, got.hum_ok);
                check_field("updated", want.updated, got.updated);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side back-pressure, including one long hold-off
    initial begin : rx_side
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 3) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin : tx_side
        int  r;
        bit  hold_done;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tuser    = 1'b0;
        frame_pos  = POS_T_MSB;
        crc_acc    = CRC_INIT;
        msb_hold   = 8'h00;
        raw_t_hold = 16'h0000;
        raw_h_hold = 16'h0000;
        t_ok_hold  = 1'b0;
        good_temp  = '0;
        good_hum   = '0;
        hold_done  = 1'b0;

        // all-zero reply straight after reset: both checks fail, reset values held
        add_row(8'h00, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b1, 0, 0, 0, 0, 0);
        // partial reply cut off by a new start; zero words give the lowest readings
        add_row(8'h12, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h34, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h81, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h81, 1'b0, 1'b1, -4500, 0, 1, 1, 1);
        // full-scale words with no start: position wraps after the sixth byte
        add_row(8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hAC, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hAC, 1'b0, 1'b1, 13000, 10000, 1, 1, 1);
        // humidity check fails: last good values stay
        add_row(8'hFF, 1'b1, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hFF, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'hAC, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b0, 0, 0, 0, 0, 0);
        add_row(8'h00, 1'b0, 1'b1, 13000, 10000, 1, 0, 0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
                      dir_rows[i].reading);
        end

        while (sent_count < ITEM_TARGET) begin
            if (sent_count >= HOLD_AT && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
            r = $urandom_range(99);
            if (r < 75) begin
                send_frame(6, ($urandom_range(4) == 0) ? 2'($urandom_range(1, 3)) : 2'b00);
            end else if (r < 88) begin
                send_frame($urandom_range(1, 5), 2'b00);
            end else begin
                send_byte(8'($urandom), $urandom_range(3) == 0, 1'b0, '0);
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/htfd_pkg.sv
rtl/core/htfd_front.sv
rtl/core/htfd_queue.sv
rtl/core/htfd_back.sv
rtl/core/humidity_temp_frame_decoder.sv
rtl/core/htfd_checker.sv
tb/tb_humidity_temp_frame_decoder.sv
